### rtl/keyed_phase_ramp_table_assert.svh
// Assertion macros used by the port-level checker.
`ifndef KEYED_PHASE_RAMP_TABLE_ASSERT_SVH
`define KEYED_PHASE_RAMP_TABLE_ASSERT_SVH
// Implication that must hold at every clock edge outside reset.
`define KPRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define KPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/kprt_pkg.sv
// Package with types and constants of the keyed phase ramp table.
`timescale 1ns / 1ps
package kprt_pkg;
  localparam int unsigned KindW = 3;
  localparam logic [2:0] KIND_SET = 3'd0;
  localparam logic [2:0] KIND_SNAP = 3'd1;
  localparam logic [2:0] KIND_READ = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_TICK = 3'd4;
  localparam logic [15:0] TransitionReset = 16'd100;

  typedef enum logic [1:0] {
    OP_UPDATE,
    OP_READ,
    OP_RELEASE,
    OP_TICK
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_INSERT,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic [16:0] phase;
    logic        busy_res;
    logic        table_full;
  } result_t;
endpackage

### rtl/kprt_if.sv
// Valid/ready channel interface for input items and results.
`timescale 1ns / 1ps
interface kprt_in_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        group;
  logic [6:0]  control_key;
  logic signed [10:0] item_index;
  logic [1:0]  channel;
  logic signed [17:0] target_phase;
  logic signed [15:0] elapsed_ms;
  modport source (output valid, kind, group, control_key, item_index, channel,
                  target_phase, elapsed_ms, input ready);
  modport sink (input valid, kind, group, control_key, item_index, channel,
                target_phase, elapsed_ms, output ready);
endinterface

interface kprt_out_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [16:0] phase;
  logic        busy_res;
  logic        table_full;
  modport source (output valid, phase, busy_res, table_full, input ready);
  modport sink (input valid, phase, busy_res, table_full, output ready);
endinterface

### rtl/kprt_front.sv
// Front part: accepts items, clamps targets and classifies them into a queue.
`timescale 1ns / 1ps
module kprt_front #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned QW = 2 + 21 + FracBits + 1 + 1 + 16 + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kprt_in_if.sink       in_if,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output logic [QW-1:0] q_data_o
);
  localparam int unsigned Depth = 2;
  logic [QW-1:0] mem_q [Depth];
  logic          wp_q, rp_q, wp_d, rp_d;
  logic [1:0]    cnt_q, cnt_d;
  kprt_pkg::op_e op;
  logic [FracBits:0] tgt;
  logic          snap;
  logic          push, pop;
  logic [20:0]   key;

  always_comb begin
    unique case (in_if.kind)
      kprt_pkg::KIND_SET, kprt_pkg::KIND_SNAP: op = kprt_pkg::OP_UPDATE;
      kprt_pkg::KIND_READ:    op = kprt_pkg::OP_READ;
      kprt_pkg::KIND_RELEASE: op = kprt_pkg::OP_RELEASE;
      kprt_pkg::KIND_TICK:    op = kprt_pkg::OP_TICK;
      default:                op = kprt_pkg::OP_READ;
    endcase
    // Kinds 5 to 7 act as a read that can never hit.
    snap = (in_if.kind == kprt_pkg::KIND_SNAP);
    if (in_if.target_phase[17]) begin
      tgt = '0;
    end else if (in_if.target_phase > $signed({1'b0, 17'(1 << FracBits)})) begin
      tgt = (FracBits + 1)'(1 << FracBits);
    end else begin
      tgt = in_if.target_phase[FracBits:0];
    end
    key = {in_if.group, in_if.control_key, in_if.item_index, in_if.channel};
  end

  assign in_if.ready = (cnt_q != 2'(Depth));
  assign push = in_if.valid && in_if.ready;
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o = mem_q[rp_q];
  assign wp_d = push ? ~wp_q : wp_q;
  assign rp_d = pop ? ~rp_q : rp_q;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= {op, key, tgt, snap, in_if.elapsed_ms,
                      (in_if.kind > kprt_pkg::KIND_TICK)};
    end
  end
endmodule

### rtl/kprt_back.sv
// Back part: sweeps the table for each queued item and produces one result.
`timescale 1ns / 1ps
module kprt_back #(
  parameter int unsigned Depth = 64,
  parameter int unsigned FracBits = 16,
  parameter int unsigned QW = 2 + 21 + FracBits + 1 + 1 + 16 + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   transition_i,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  logic [QW-1:0] q_data_i,
  kprt_out_if.source    out_if
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned PW = FracBits + 1;
  localparam int unsigned NW = 16 + FracBits;
  localparam logic [PW-1:0] One = PW'(1 << FracBits);

  kprt_pkg::back_state_e state_q, state_d;
  logic [Depth-1:0] valid_q, valid_d;
  logic [20:0]      key_mem [Depth];
  logic [PW-1:0]    val_mem [Depth];
  logic [PW-1:0]    tgt_mem [Depth];

  logic [1:0]    op_q;
  logic [20:0]   ikey_q;
  logic [PW-1:0] itgt_q;
  logic          isnap_q, inull_q;
  logic [15:0]   iel_q;
  logic [AW:0]   idx_q, idx_d;
  logic          hit_q, hit_d, free_f_q, free_f_d, busy_q, busy_d;
  logic [AW-1:0] free_q, free_d;
  logic [PW-1:0] rdphase_q, rdphase_d;
  logic [PW-1:0] step;
  logic [NW-1:0] rem_q, quo_q;
  logic [16:0]   dcnt_q;
  logic [5:0]    dbit_q;
  logic          res_v_q;
  kprt_pkg::result_t res_q, res_d;
  logic          full_d;

  // Read stage of the sweep: entry data arrives in the cycle after its address.
  logic          scan_v_q;
  logic [AW-1:0] pix_q;
  logic          ev_q;
  logic [20:0]   kd_q;
  logic [PW-1:0] cv_q, ct_q;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] ix;
  logic          ev;
  logic [PW-1:0] cv, ct, nv;
  logic          wr_en;
  logic [PW-1:0] wr_val, wr_tgt;
  logic [AW-1:0] wr_addr;
  logic          wr_key;
  logic          kmatch;
  logic [PW:0]   dpos, dneg;
  logic          load, tail, cnt_in;
  logic [NW:0]   rsh;
  logic [15:0]   tdiv;

  assign rd_addr = idx_q[AW-1:0];
  assign ix = pix_q;
  assign ev = ev_q;
  assign cv = cv_q;
  assign ct = ct_q;
  assign kmatch = (kd_q == ikey_q);
  assign dpos = {1'b0, ct} - {1'b0, cv};
  assign dneg = {1'b0, cv} - {1'b0, ct};
  assign q_ready_o = (state_q == kprt_pkg::ST_IDLE) && !res_v_q;
  assign load = q_valid_i && q_ready_o;
  assign tdiv = (transition_i == '0) ? 16'd1 : transition_i;
  assign rsh = {rem_q, quo_q[NW-1]};
  assign out_if.valid = res_v_q;
  assign out_if.phase = 17'(rdphase_q);
  assign out_if.busy_res = res_q.busy_res;
  assign out_if.table_full = res_q.table_full;
  assign tail = 1'b0;
  assign cnt_in = tail;

  // The quotient stays fixed during the sweep, so the step is taken from it directly.
  assign step = (op_q == 2'(kprt_pkg::OP_TICK) && !iel_q[15] && iel_q != '0 &&
                 quo_q <= NW'(One)) ? quo_q[PW-1:0] : One;

  // Next value of one entry under a tick.
  always_comb begin
    if (cv == ct) begin
      nv = cv;
    end else if (ct > cv) begin
      nv = (dpos <= {1'b0, step}) ? ct : cv + step;
    end else begin
      nv = (dneg <= {1'b0, step}) ? ct : cv - step;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    hit_d = hit_q;
    free_f_d = free_f_q;
    free_d = free_q;
    busy_d = busy_q;
    rdphase_d = rdphase_q;
    valid_d = valid_q;
    wr_en = 1'b0;
    wr_key = 1'b0;
    wr_addr = ix;
    wr_val = cv;
    wr_tgt = ct;
    full_d = 1'b0;
    res_d = res_q;
    unique case (state_q)
      kprt_pkg::ST_IDLE: begin
        if (load) begin
          idx_d = '0;
          hit_d = 1'b0;
          free_f_d = 1'b0;
          busy_d = 1'b0;
          rdphase_d = '0;
          state_d = (q_data_i[QW-1 -: 2] == 2'(kprt_pkg::OP_TICK) &&
                     !q_data_i[16] && q_data_i[16:1] != '0)
                    ? kprt_pkg::ST_DIV : kprt_pkg::ST_SCAN;
        end
      end
      kprt_pkg::ST_DIV: begin
        if (dbit_q == '0) state_d = kprt_pkg::ST_SCAN;
      end
      kprt_pkg::ST_SCAN: begin
        if (scan_v_q) begin
          if (!ev) begin
            if (!free_f_d) begin
              free_f_d = 1'b1;
              free_d = ix;
            end
          end else begin
            unique case (kprt_pkg::op_e'(op_q))
              kprt_pkg::OP_UPDATE: begin
                if (kmatch && !hit_q) begin
                  hit_d = 1'b1;
                  wr_en = 1'b1;
                  wr_tgt = itgt_q;
                  if (isnap_q) wr_val = itgt_q;
                  busy_d = busy_q | ((isnap_q ? itgt_q : cv) != itgt_q);
                end else begin
                  busy_d = busy_q | (cv != ct);
                end
              end
              kprt_pkg::OP_READ: begin
                if (kmatch && !inull_q && !hit_q) begin
                  hit_d = 1'b1;
                  rdphase_d = cv;
                end
                busy_d = busy_q | (cv != ct);
              end
              kprt_pkg::OP_RELEASE: begin
                if (kd_q[1:0] == ikey_q[1:0]) begin
                  wr_en = 1'b1;
                  wr_tgt = '0;
                  busy_d = busy_q | (cv != '0);
                end else begin
                  busy_d = busy_q | (cv != ct);
                end
              end
              default: begin
                wr_en = 1'b1;
                wr_val = nv;
                if (nv == '0 && ct == '0) begin
                  valid_d[ix] = 1'b0;
                end else begin
                  busy_d = busy_q | (nv != ct);
                end
              end
            endcase
          end
          if (ix == AW'(Depth - 1)) begin
            state_d = (op_q == 2'(kprt_pkg::OP_UPDATE) && !hit_d && itgt_q != '0)
                      ? kprt_pkg::ST_INSERT : kprt_pkg::ST_DONE;
          end
        end
        if (idx_q != (AW + 1)'(Depth)) idx_d = idx_q + 1'b1;
      end
      kprt_pkg::ST_INSERT: begin
        if (free_f_q) begin
          wr_en = 1'b1;
          wr_key = 1'b1;
          wr_addr = free_q;
          wr_tgt = itgt_q;
          wr_val = isnap_q ? itgt_q : '0;
          valid_d[free_q] = 1'b1;
          busy_d = busy_q | !isnap_q;
        end else begin
          full_d = 1'b1;
        end
        state_d = kprt_pkg::ST_DONE;
      end
      kprt_pkg::ST_DONE: begin
        state_d = kprt_pkg::ST_IDLE;
      end
      default: state_d = kprt_pkg::ST_IDLE;
    endcase
    if (state_q == kprt_pkg::ST_INSERT) begin
      res_d.table_full = full_d;
    end else if (state_q == kprt_pkg::ST_IDLE && load) begin
      res_d.table_full = 1'b0;
    end
    res_d.busy_res = busy_d;
    res_d.phase = 17'(rdphase_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kprt_pkg::ST_IDLE;
      valid_q <= '0;
      res_v_q <= 1'b0;
      idx_q <= '0;
      dbit_q <= '0;
      scan_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q <= idx_d;
      scan_v_q <= (state_q == kprt_pkg::ST_SCAN) && (idx_q != (AW + 1)'(Depth));
      if (state_q == kprt_pkg::ST_DONE) begin
        res_v_q <= 1'b1;
      end else if (out_if.ready) begin
        res_v_q <= 1'b0;
      end
      if (load) begin
        dbit_q <= 6'(NW - 1);
      end else if (state_q == kprt_pkg::ST_DIV && dbit_q != '0) begin
        dbit_q <= dbit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    free_f_q <= free_f_d;
    free_q <= free_d;
    busy_q <= busy_d;
    rdphase_q <= rdphase_d;
    res_q <= res_d;
    dcnt_q <= {1'b0, tdiv};
    pix_q <= rd_addr;
    ev_q <= valid_q[rd_addr];
    kd_q <= key_mem[rd_addr];
    cv_q <= val_mem[rd_addr];
    ct_q <= tgt_mem[rd_addr];
    if (load) begin
      op_q <= q_data_i[QW-1 -: 2];
      ikey_q <= q_data_i[QW-3 -: 21];
      itgt_q <= q_data_i[QW-24 -: PW];
      isnap_q <= q_data_i[17];
      iel_q <= q_data_i[16:1];
      inull_q <= q_data_i[0];
      rem_q <= '0;
      quo_q <= NW'({q_data_i[16:1], FracBits'(0)});
    end else if (state_q == kprt_pkg::ST_DIV) begin
      // Restoring division, one quotient bit per cycle.
      if (rsh >= {1'b0, NW'(dcnt_q)}) begin
        rem_q <= NW'(rsh - {1'b0, NW'(dcnt_q)});
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= NW'(rsh);
        quo_q <= {quo_q[NW-2:0], cnt_in};
      end
    end
    if (wr_en) begin
      val_mem[wr_addr] <= wr_val;
      tgt_mem[wr_addr] <= wr_tgt;
    end
    if (wr_key) key_mem[wr_addr] <= ikey_q;
  end
endmodule

### rtl/keyed_phase_ramp_table.sv
// Top level of the keyed phase ramp table.
// Items enter on in_if (valid/ready) and each yields one result on out_if.
// A front queue of two entries accepts and classifies items; the back part
// sweeps every table entry once per item, one entry per cycle, with the
// entry data read in the cycle after its address.
// From the input transfer, an item passes the queue, a bit-serial step
// division (only for a tick with positive elapsed time), the sweep of every
// entry, an insert step when a set or snap with a nonzero target finds no
// entry, and a done state before the result is valid. The back part takes
// its next item in the cycle after the result transfer, so it works on one
// item at a time.
// The result register holds its value until the receiver takes the transfer;
// while it waits, the back part takes no new item and the queue fills up.
// Reset clears every valid bit, the queue and the result; transition_ms
// returns to 100. Write transition_ms through cfg_we_i only while idle.
// Keys compare as raw bit patterns; kinds 5 to 7 return a zero phase and
// change nothing.
`timescale 1ns / 1ps
module keyed_phase_ramp_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  kprt_in_if.sink     in_if,
  kprt_out_if.source  out_if
);
  localparam int unsigned QW = 2 + 21 + PHASE_FRAC_BITS + 1 + 1 + 16 + 1;
  logic [15:0]   transition_q;
  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transition_q <= kprt_pkg::TransitionReset;
    end else if (cfg_we_i) begin
      transition_q <= cfg_wdata_i;
    end
  end

  kprt_front #(.FracBits(PHASE_FRAC_BITS), .QW(QW)) u_front (
    .clk_i, .rst_ni, .in_if,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  kprt_back #(.Depth(TABLE_DEPTH), .FracBits(PHASE_FRAC_BITS), .QW(QW)) u_back (
    .clk_i, .rst_ni, .transition_i(transition_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data), .out_if
  );
endmodule

### rtl/kprt_checker.sv
// Port-level checker for the keyed phase ramp table, bound to the top level.
`timescale 1ns / 1ps
`include "keyed_phase_ramp_table_assert.svh"
module kprt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_phase,
  input logic        out_full
);
  `KPRT_ASSERT_IMP(a_phase_range, clk_i, rst_ni, out_valid,
                   out_phase <= 17'h10000, "phase out of range")
  `KPRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready,
                    out_valid, "result dropped")
  `KPRT_ASSERT_IMP(a_full_no_phase, clk_i, rst_ni, out_valid && out_full,
                   out_phase == '0, "full with phase")
endmodule

bind keyed_phase_ramp_table kprt_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_phase(out_if.phase), .out_full(out_if.table_full)
);

### tb/keyed_phase_ramp_table_tb.sv
// Self-checking testbench of the keyed phase ramp table: directed and random traffic against a predictor.
`timescale 1ns / 1ps
module keyed_phase_ramp_table_tb;
  localparam int Depth = 64;
  localparam int PhaseOne = 1 << 16;
  localparam logic [2:0] KIND_SPARE = 3'd5;
  localparam int PoolSize = 16;

  typedef struct packed {
    logic [2:0]         kind;
    logic               grp;
    logic [6:0]         key;
    logic signed [10:0] idx;
    logic [1:0]         ch;
    logic signed [17:0] tgt;
    logic signed [15:0] el;
  } item_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  kprt_in_if in_if (clk);
  kprt_out_if out_if (clk);

  keyed_phase_ramp_table u_dut (
    .clk_i(clk), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_if(in_if), .out_if(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the phase table.
  bit        slot_v [Depth];
  logic      slot_grp [Depth];
  logic [6:0] slot_key [Depth];
  logic [10:0] slot_idx [Depth];
  logic [1:0] slot_ch [Depth];
  int        slot_val [Depth];
  int        slot_tgt [Depth];
  int        ramp_ms = 100;

  item_t   pending_q[$];
  kprt_pkg::result_t expected_q[$];
  item_t   key_pool[PoolSize];
  int      errors = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;
  bit      hold_on = 1'b0;

  function automatic int find_slot(item_t it);
    for (int i = 0; i < Depth; i++)
      if (slot_v[i] && slot_grp[i] == it.grp && slot_key[i] == it.key &&
          slot_idx[i] == it.idx && slot_ch[i] == it.ch)
        return i;
    return -1;
  endfunction

  function automatic kprt_pkg::result_t apply_item(item_t it);
    kprt_pkg::result_t r;
    int hit;
    int t;
    int step;
    int d;
    longint q;
    r = '0;
    case (it.kind)
      kprt_pkg::KIND_SET, kprt_pkg::KIND_SNAP: begin
        t = it.tgt;
        if (t < 0) t = 0;
        if (t > PhaseOne) t = PhaseOne;
        hit = find_slot(it);
        if (hit >= 0) begin
          slot_tgt[hit] = t;
          if (it.kind == kprt_pkg::KIND_SNAP) slot_val[hit] = t;
        end else if (t > 0) begin
          hit = -1;
          for (int i = 0; i < Depth; i++)
            if (!slot_v[i] && hit < 0) hit = i;
          if (hit < 0) begin
            r.table_full = 1'b1;
          end else begin
            slot_v[hit] = 1'b1;
            slot_grp[hit] = it.grp;
            slot_key[hit] = it.key;
            slot_idx[hit] = it.idx;
            slot_ch[hit] = it.ch;
            slot_tgt[hit] = t;
            slot_val[hit] = (it.kind == kprt_pkg::KIND_SNAP) ? t : 0;
          end
        end
      end
      kprt_pkg::KIND_READ: begin
        hit = find_slot(it);
        if (hit >= 0) r.phase = slot_val[hit][16:0];
      end
      kprt_pkg::KIND_RELEASE: begin
        for (int i = 0; i < Depth; i++)
          if (slot_v[i] && slot_ch[i] == it.ch) slot_tgt[i] = 0;
      end
      kprt_pkg::KIND_TICK: begin
        if (it.el <= 0) begin
          step = PhaseOne;
        end else begin
          q = (longint'(it.el) << 16) / ((ramp_ms == 0) ? 1 : ramp_ms);
          step = (q > PhaseOne) ? PhaseOne : int'(q);
        end
        for (int i = 0; i < Depth; i++) begin
          if (slot_v[i]) begin
            d = slot_tgt[i] - slot_val[i];
            if (d != 0) begin
              if ((d < 0 ? -d : d) <= step) slot_val[i] = slot_tgt[i];
              else slot_val[i] += (d > 0) ? step : -step;
            end
            if (slot_val[i] <= 0 && slot_tgt[i] <= 0) slot_v[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < Depth; i++)
      if (slot_v[i] && slot_val[i] != slot_tgt[i]) r.busy_res = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Driver: one item at a time from the pending queue, with random gaps.
  int send_gap = 0;
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.kind <= '0; in_if.group <= '0; in_if.control_key <= '0;
      in_if.item_index <= '0; in_if.channel <= '0;
      in_if.target_phase <= '0; in_if.elapsed_ms <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_q = {expected_q, apply_item(pending_q.pop_front())};
      end
      if (in_if.valid && !in_if.ready) begin
        // Hold the offered item until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 10);
        in_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.kind <= pending_q[0].kind;
        in_if.group <= pending_q[0].grp;
        in_if.control_key <= pending_q[0].key;
        in_if.item_index <= pending_q[0].idx;
        in_if.channel <= pending_q[0].ch;
        in_if.target_phase <= pending_q[0].tgt;
        in_if.elapsed_ms <= pending_q[0].el;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // One long hold-off of the receiver, counted here in cycles.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (600) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Monitor: random stalls, the long hold-off, and the result check.
  int stall = 0;
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result transfer at %0t", $time);
          errors++;
        end else begin
          kprt_pkg::result_t want;
          want = expected_q.pop_front();
          if (out_if.phase !== want.phase)
            report_mismatch("phase", int'(out_if.phase), int'(want.phase));
          if (out_if.busy_res !== want.busy_res)
            report_mismatch("busy_res", int'(out_if.busy_res), int'(want.busy_res));
          if (out_if.table_full !== want.table_full)
            report_mismatch("table_full", int'(out_if.table_full),
                            int'(want.table_full));
        end
      end
      if (hold_on) begin
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic item_t make_item(logic [2:0] kind, int grp, int key,
                                      int idx, int ch, int tgt, int el);
    item_t it;
    it.kind = kind; it.grp = grp[0]; it.key = key[6:0]; it.idx = idx[10:0];
    it.ch = ch[1:0]; it.tgt = tgt[17:0]; it.el = el[15:0];
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    if ($urandom_range(0, 99) < 85) it = key_pool[$urandom_range(0, PoolSize - 1)];
    else it = item_t'(58'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 30) it.kind = kprt_pkg::KIND_SET;
    else if (pick < 42) it.kind = kprt_pkg::KIND_SNAP;
    else if (pick < 65) it.kind = kprt_pkg::KIND_READ;
    else if (pick < 70) it.kind = kprt_pkg::KIND_RELEASE;
    else if (pick < 95) it.kind = kprt_pkg::KIND_TICK;
    else it.kind = 3'($urandom_range(KIND_SPARE, 7));
    pick = $urandom_range(0, 9);
    if (pick < 4) it.tgt = 18'($urandom_range(1, PhaseOne));
    else if (pick < 6) it.tgt = '0;
    else if (pick < 7) it.tgt = 18'(PhaseOne);
    else it.tgt = 18'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 5) it.el = 16'($urandom_range(1, 200));
    else if (pick < 7) it.el = -16'sd1 * 16'($urandom_range(0, 32768));
    else it.el = 16'($urandom);
    return it;
  endfunction

  task automatic wait_idle();
    wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_if.valid);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_ramp(logic [15:0] ms);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    ramp_ms = int'(ms);
  endtask

  task automatic add_item(item_t it);
    pending_q = {pending_q, it};
  endtask

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) add_item(random_item());
  endtask

  initial begin
    for (int i = 0; i < PoolSize; i++) key_pool[i] = item_t'(58'({$urandom, $urandom}));
    key_pool[0].idx = -11'sd1;
    key_pool[1].ch = 2'd3;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    // Directed: clamping, absent keys, snap, release, ticks, unused kinds.
    add_item(make_item(kprt_pkg::KIND_READ, 0, 5, 3, 0, 0, 0));
    add_item(make_item(kprt_pkg::KIND_SET, 0, 5, 3, 0, 0, 0));
    add_item(make_item(kprt_pkg::KIND_SET, 0, 5, 3, 0, -131072, 0));
    add_item(make_item(kprt_pkg::KIND_SET, 1, 127, -1, 1, 131071, 0));
    add_item(make_item(kprt_pkg::KIND_SNAP, 0, 0, 1023, 2, 40000, 0));
    add_item(make_item(kprt_pkg::KIND_SET, 0, 9, 0, 3, 1, 0));
    add_item(make_item(kprt_pkg::KIND_READ, 1, 127, -1, 1, 0, 0));
    add_item(make_item(kprt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 10));
    add_item(make_item(kprt_pkg::KIND_READ, 1, 127, -1, 1, 0, 0));
    add_item(make_item(kprt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 32767));
    add_item(make_item(kprt_pkg::KIND_READ, 0, 0, 1023, 2, 0, 0));
    add_item(make_item(kprt_pkg::KIND_RELEASE, 1, 3, 5, 2, 0, 0));
    add_item(make_item(kprt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
    add_item(make_item(kprt_pkg::KIND_SNAP, 0, 0, 1023, 2, 0, 0));
    add_item(make_item(kprt_pkg::KIND_TICK, 0, 0, 0, 0, 0, -32768));
    add_item(make_item(KIND_SPARE, 1, 1, 1, 1, 500, 5));
    add_item(make_item(3'd7, 0, 9, 0, 3, 500, 5));
    add_item(make_item(kprt_pkg::KIND_RELEASE, 0, 0, 0, 3, 0, 0));
    add_item(make_item(kprt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 1));
    add_item(make_item(kprt_pkg::KIND_READ, 0, 9, 0, 3, 0, 0));
    // Fill the table past its depth, then empty it.
    for (int i = 0; i < Depth + 4; i++)
      add_item(make_item(kprt_pkg::KIND_SET, i, i, i, i, 1000 + i, 0));
    for (int c = 0; c < 4; c++)
      add_item(make_item(kprt_pkg::KIND_RELEASE, 0, 0, 0, c, 0, 0));
    add_item(make_item(kprt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0));
    random_burst(300);
    write_ramp(16'd1);
    hold_req = 1'b1;
    random_burst(400);
    write_ramp(16'd65535);
    random_burst(300);
    write_ramp(16'($urandom_range(2, 5000)));
    random_burst(400);
    write_ramp(16'd100);
    random_burst(250);
    wait_idle();
    calm = 1'b1;
    random_burst(200);
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
